FILE: sv/scfc_pkg.sv
// Shared types, codes and constants for the serial command frame controller.
// Depends on nothing; imported by scfc_out_queue, serial_command_frame_controller and the bench files.
`default_nettype none

package scfc_pkg;

  // command word actions
  localparam logic [1:0] ACT_BYTE   = 2'd0;
  localparam logic [1:0] ACT_BUTTON = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_CODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_CODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEV1_CODE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEV2_CODE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEV3_CODE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 3'd6;

  // register reset values
  localparam logic [7:0]  RST_DIM_CODE    = 8'd1;
  localparam logic [7:0]  RST_STATUS_CODE = 8'd2;
  localparam logic [7:0]  RST_DEV1_CODE   = 8'd1;
  localparam logic [7:0]  RST_DEV2_CODE   = 8'd2;
  localparam logic [7:0]  RST_DEV3_CODE   = 8'd3;
  localparam logic [7:0]  RST_THRESHOLD   = 8'd50;
  localparam logic [23:0] RST_TIMEOUT     = 24'hFFFFF;

  // frame bytes
  localparam logic [7:0] START_BYTE = 8'h2A;
  localparam logic [7:0] END_BYTE   = 8'h23;
  localparam logic [7:0] REPLY_TAG  = 8'h01;

  // frame body layout
  localparam int unsigned BODY_LEN = 11;
  localparam int unsigned ADDR_W   = 4;
  localparam logic [ADDR_W-1:0] BODY_LAST = 4'd10;
  localparam logic [ADDR_W-1:0] FUNC_POS  = 4'd0;
  localparam logic [ADDR_W-1:0] DEV_POS   = 4'd1;
  localparam logic [ADDR_W-1:0] LEVEL_POS = 4'd9;

  // reply frame layout
  localparam logic [3:0] RPL_START = 4'd0;
  localparam logic [3:0] RPL_FUNC  = 4'd1;
  localparam logic [3:0] RPL_DEV   = 4'd2;
  localparam logic [3:0] RPL_TAG   = 4'd3;
  localparam logic [3:0] RPL_BIT   = 4'd11;
  localparam logic [3:0] RPL_END   = 4'd12;
  localparam logic [1:0] DEV_LAST  = 2'd2;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_RECEIVING = 3'd1,
    EV_ACCEPTED  = 3'd2,
    EV_BAD_END   = 3'd3,
    EV_TIMEOUT   = 3'd4
  } frame_event_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_DEV,
    S_RD_LEVEL,
    S_APPLY,
    S_REPLY,
    S_REPORT
  } state_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
    logic [2:0] button_mask;
  } cmd_word_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] tx_byte;
    logic       last_of_run;
    logic [2:0] device_outputs;
    logic [2:0] frame_event;
  } rsp_word_t;

  // byte at one position of a reply frame
  function automatic logic [7:0] reply_byte(input logic [3:0] pos,
                                            input logic [7:0] status,
                                            input logic [7:0] code,
                                            input logic       dev_bit);
    logic [7:0] b;
    case (pos)
      RPL_START: b = START_BYTE;
      RPL_FUNC:  b = status;
      RPL_DEV:   b = code;
      RPL_TAG:   b = REPLY_TAG;
      RPL_BIT:   b = {7'd0, dev_bit};
      RPL_END:   b = END_BYTE;
      default:   b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: sv/scfc_out_queue.sv
// Two-entry response queue that decouples the sequencer from the response stall.
// Depends on scfc_pkg for the response word type.
`default_nettype none

module scfc_out_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire scfc_pkg::rsp_word_t push_word,
  output logic                    space,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output scfc_pkg::rsp_word_t     rsp
);
  import scfc_pkg::*;

  rsp_word_t  slot0;
  rsp_word_t  slot1;
  logic [1:0] count;
  logic       pop;
  logic       to_head;

  // head always sits in slot0
  assign rsp_valid = (count != 2'd0);
  assign rsp       = slot0;
  assign pop       = rsp_valid && !rsp_stall;
  assign space     = (count != 2'd2) || pop;

  // a pushed word lands at the head when the queue is empty after any pop
  assign to_head   = pop ? (count == 2'd1) : (count == 2'd0);

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // slot data, shifting toward the head on pop
  always_ff @(posedge clk) begin
    if (push && to_head) begin
      slot0 <= push_word;
    end else if (pop) begin
      slot0 <= slot1;
    end
    if (push && !to_head) begin
      slot1 <= push_word;
    end
  end

endmodule

`default_nettype wire

FILE: sv/serial_command_frame_controller.sv
// Serial command frame controller: frame collection, decode, replies and button toggles.
// Report: a taken word's report is queued in the same cycle; a '#'-ended frame reports last.
// Throughput: one command word per cycle while idle with queue space; a frame ending in '#'
// holds input through body read-back (S_RD_DEV, S_RD_LEVEL, S_APPLY), 39 reply words and
// the report, or the report alone for any other function byte; response stalls add to both.
// Reset (rst, synchronous): registers to defaults, idle, all devices off.
`default_nettype none

module serial_command_frame_controller (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cmd_valid,
  output logic                                    cmd_stall,
  input  wire scfc_pkg::cmd_word_t                cmd,
  output logic                                    rsp_valid,
  input  wire logic                               rsp_stall,
  output scfc_pkg::rsp_word_t                     rsp,
  input  wire logic                               cfg_we,
  input  wire logic [scfc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [scfc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import scfc_pkg::*;

  // configuration registers
  logic [7:0]  dim_code;
  logic [7:0]  status_code;
  logic [7:0]  dev1_code;
  logic [7:0]  dev2_code;
  logic [7:0]  dev3_code;
  logic [7:0]  threshold;
  logic [23:0] timeout;

  // control state
  state_t      state, state_next;
  logic        receiving, receiving_next;
  logic [3:0]  byte_count, byte_count_next;
  logic [23:0] tick_count, tick_count_next;
  logic [2:0]  dev_state, dev_state_next;
  logic [1:0]  dev_idx, dev_idx_next;
  logic [3:0]  byte_idx, byte_idx_next;
  logic [7:0]  func, func_next;
  logic [7:0]  dev_sel, dev_sel_next;

  // frame body memory
  logic [7:0]        body_mem [BODY_LEN];
  logic              mem_we;
  logic              mem_rd_en;
  logic [ADDR_W-1:0] mem_rd_addr;
  logic [7:0]        mem_rd_data;

  // queue side
  logic         q_push;
  rsp_word_t    q_word;
  logic         q_space;
  logic         cmd_take;
  logic         report;
  frame_event_t ev;
  logic [7:0]   code_sel;
  logic [2:0]   hit_mask;

  assign cmd_stall = (state != S_IDLE) || !q_space;
  assign cmd_take  = cmd_valid && !cmd_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dim_code    <= RST_DIM_CODE;
      status_code <= RST_STATUS_CODE;
      dev1_code   <= RST_DEV1_CODE;
      dev2_code   <= RST_DEV2_CODE;
      dev3_code   <= RST_DEV3_CODE;
      threshold   <= RST_THRESHOLD;
      timeout     <= RST_TIMEOUT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIM_CODE:    dim_code    <= cfg_data[7:0];
        REG_STATUS_CODE: status_code <= cfg_data[7:0];
        REG_DEV1_CODE:   dev1_code   <= cfg_data[7:0];
        REG_DEV2_CODE:   dev2_code   <= cfg_data[7:0];
        REG_DEV3_CODE:   dev3_code   <= cfg_data[7:0];
        REG_THRESHOLD:   threshold   <= cfg_data[7:0];
        REG_TIMEOUT:     timeout     <= cfg_data;
        default:         ;
      endcase
    end
  end

  // body memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      body_mem[byte_count] <= cmd.rx_byte;
    end
    if (mem_rd_en) begin
      mem_rd_data <= body_mem[mem_rd_addr];
    end
  end

  // device code for the reply in progress
  always_comb begin
    case (dev_idx)
      2'd0:    code_sel = dev1_code;
      2'd1:    code_sel = dev2_code;
      default: code_sel = dev3_code;
    endcase
  end

  // lowest matching output wins for a dim command
  always_comb begin
    hit_mask = 3'b000;
    if (dev_sel == dev1_code) begin
      hit_mask = 3'b001;
    end else if (dev_sel == dev2_code) begin
      hit_mask = 3'b010;
    end else if (dev_sel == dev3_code) begin
      hit_mask = 3'b100;
    end
  end

  // sequencer: command handling, body read-back, reply emission
  always_comb begin
    state_next      = state;
    receiving_next  = receiving;
    byte_count_next = byte_count;
    tick_count_next = tick_count;
    dev_state_next  = dev_state;
    dev_idx_next    = dev_idx;
    byte_idx_next   = byte_idx;
    func_next       = func;
    dev_sel_next    = dev_sel;
    mem_we          = 1'b0;
    mem_rd_en       = 1'b0;
    mem_rd_addr     = FUNC_POS;
    q_push          = 1'b0;
    q_word          = '0;
    report          = 1'b0;
    ev              = receiving ? EV_RECEIVING : EV_NONE;
    case (state)
      S_IDLE: begin
        if (cmd_take) begin
          report = 1'b1;
          case (cmd.action)
            ACT_BYTE: begin
              if (!receiving) begin
                if (cmd.rx_byte == START_BYTE) begin
                  receiving_next  = 1'b1;
                  byte_count_next = 4'd0;
                  tick_count_next = 24'd0;
                  ev              = EV_RECEIVING;
                end else begin
                  ev = EV_NONE;
                end
              end else begin
                mem_we = 1'b1;
                if (byte_count == BODY_LAST) begin
                  receiving_next  = 1'b0;
                  byte_count_next = 4'd0;
                  tick_count_next = 24'd0;
                  if (cmd.rx_byte == END_BYTE) begin
                    // decode runs from the body memory; report comes at the end
                    ev          = EV_ACCEPTED;
                    report      = 1'b0;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = FUNC_POS;
                    state_next  = S_RD_DEV;
                  end else begin
                    ev = EV_BAD_END;
                  end
                end else begin
                  byte_count_next = byte_count + 4'd1;
                  ev              = EV_RECEIVING;
                end
              end
            end
            ACT_BUTTON: begin
              if (!receiving) begin
                if (cmd.button_mask[0]) begin
                  dev_state_next = dev_state ^ 3'b001;
                end else if (cmd.button_mask[1]) begin
                  dev_state_next = dev_state ^ 3'b010;
                end else if (cmd.button_mask[2]) begin
                  dev_state_next = dev_state ^ 3'b100;
                end
                ev = EV_NONE;
              end
            end
            ACT_TICK: begin
              if (receiving) begin
                if (tick_count >= timeout) begin
                  receiving_next  = 1'b0;
                  byte_count_next = 4'd0;
                  tick_count_next = 24'd0;
                  ev              = EV_TIMEOUT;
                end else begin
                  tick_count_next = tick_count + 24'd1;
                  ev              = EV_RECEIVING;
                end
              end
            end
            default: ;
          endcase
          if (report) begin
            q_push = 1'b1;
            q_word = '{has_byte: 1'b0, tx_byte: 8'd0, last_of_run: 1'b1,
                       device_outputs: dev_state_next, frame_event: ev};
          end
        end
      end
      S_RD_DEV: begin
        func_next   = mem_rd_data;
        mem_rd_en   = 1'b1;
        mem_rd_addr = DEV_POS;
        state_next  = S_RD_LEVEL;
      end
      S_RD_LEVEL: begin
        dev_sel_next = mem_rd_data;
        mem_rd_en    = 1'b1;
        mem_rd_addr  = LEVEL_POS;
        state_next   = S_APPLY;
      end
      S_APPLY: begin
        // read data now holds the level byte
        if (func == dim_code) begin
          if (mem_rd_data > threshold) begin
            dev_state_next = dev_state | hit_mask;
          end else begin
            dev_state_next = dev_state & ~hit_mask;
          end
        end
        dev_idx_next  = 2'd0;
        byte_idx_next = 4'd0;
        if ((func == dim_code) || (func == status_code)) begin
          state_next = S_REPLY;
        end else begin
          state_next = S_REPORT;
        end
      end
      S_REPLY: begin
        if (q_space) begin
          q_push = 1'b1;
          q_word = '{has_byte: 1'b1,
                     tx_byte: reply_byte(byte_idx, status_code, code_sel,
                                         dev_state[dev_idx]),
                     last_of_run: 1'b0, device_outputs: dev_state,
                     frame_event: EV_ACCEPTED};
          if (byte_idx == RPL_END) begin
            byte_idx_next = 4'd0;
            if (dev_idx == DEV_LAST) begin
              state_next = S_REPORT;
            end else begin
              dev_idx_next = dev_idx + 2'd1;
            end
          end else begin
            byte_idx_next = byte_idx + 4'd1;
          end
        end
      end
      S_REPORT: begin
        if (q_space) begin
          q_push     = 1'b1;
          q_word     = '{has_byte: 1'b0, tx_byte: 8'd0, last_of_run: 1'b1,
                         device_outputs: dev_state, frame_event: EV_ACCEPTED};
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      receiving  <= 1'b0;
      byte_count <= 4'd0;
      tick_count <= 24'd0;
      dev_state  <= 3'b000;
      dev_idx    <= 2'd0;
      byte_idx   <= 4'd0;
    end else begin
      state      <= state_next;
      receiving  <= receiving_next;
      byte_count <= byte_count_next;
      tick_count <= tick_count_next;
      dev_state  <= dev_state_next;
      dev_idx    <= dev_idx_next;
      byte_idx   <= byte_idx_next;
    end
  end

  // decoded frame fields
  always_ff @(posedge clk) begin
    func    <= func_next;
    dev_sel <= dev_sel_next;
  end

  // response queue
  scfc_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (q_word),
    .space     (q_space),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

`ifndef SYNTHESIS
  // a command word is only taken while the sequencer is idle
  a_take_idle : assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |-> (state == S_IDLE))
    else $error("command word taken while sequencer busy");

  // body write pointer stays inside the frame body
  a_count_range : assert property (@(posedge clk) disable iff (rst)
    byte_count <= BODY_LAST)
    else $error("frame byte count out of range");

  // idle receiver keeps its counters cleared
  a_idle_clear : assert property (@(posedge clk) disable iff (rst)
    !receiving |-> ((byte_count == 4'd0) && (tick_count == 24'd0)))
    else $error("frame counters not cleared while idle");

  // the reply is followed by the report
  a_reply_end : assert property (@(posedge clk) disable iff (rst)
    ((state == S_REPLY) && q_space && (byte_idx == RPL_END) && (dev_idx == DEV_LAST))
      |=> (state == S_REPORT))
    else $error("reply did not end in a report");
`endif

endmodule

`default_nettype wire

FILE: bench/scfc_checker.sv
// Checker for the serial command frame controller: tracks config writes, predicts
// response words for each accepted command word and compares them in order.
// Depends on scfc_pkg for the word types, register indexes and frame constants.
module scfc_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  input  logic                            cmd_stall,
  input  scfc_pkg::cmd_word_t             cmd,
  input  logic                            rsp_valid,
  input  logic                            rsp_stall,
  input  scfc_pkg::rsp_word_t             rsp,
  input  logic                            cfg_we,
  input  logic [scfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scfc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending,
  output logic                            frame_open
);
  timeunit 1ns;
  timeprecision 1ps;
  import scfc_pkg::*;

  localparam int unsigned REPLY_BYTES = 13;
  localparam int unsigned SHOW_LIMIT = 10;

  // shadow of the configuration registers
  logic [7:0]  dim_code;
  logic [7:0]  status_code;
  logic [7:0]  dev_code [3];
  logic [7:0]  threshold;
  logic [23:0] timeout_lim;

  // shadow of the frame receiver and the device outputs
  logic        receiving;
  logic [7:0]  body [BODY_LEN];
  int          body_count;
  logic [23:0] tick_count;
  logic [2:0]  devices;

  rsp_word_t   due_responses [$];

  task automatic flag_failure(input string msg);
    fail_count++;
    if (fail_count <= SHOW_LIMIT) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  task automatic push_word(input logic has, input logic [7:0] b, input logic last,
                           input frame_event_t ev);
    rsp_word_t w;
    w.has_byte       = has;
    w.tx_byte        = b;
    w.last_of_run    = last;
    w.device_outputs = devices;
    w.frame_event    = ev;
    due_responses.push_back(w);
  endtask

  task automatic drop_frame();
    for (int i = 0; i < BODY_LEN; i++) body[i] = 8'h00;
    body_count = 0;
    tick_count = '0;
    receiving  = 1'b0;
  endtask

  // three status frames, one per device
  task automatic push_status_frames();
    logic [7:0] b;
    for (int d = 0; d < 3; d++) begin
      for (int i = 0; i < REPLY_BYTES; i++) begin
        case (i)
          RPL_START: b = START_BYTE;
          RPL_FUNC:  b = status_code;
          RPL_DEV:   b = dev_code[d];
          RPL_TAG:   b = REPLY_TAG;
          RPL_BIT:   b = {7'd0, devices[d]};
          RPL_END:   b = END_BYTE;
          default:   b = 8'h00;
        endcase
        push_word(1'b1, b, 1'b0, EV_ACCEPTED);
      end
    end
  endtask

  // act on a complete frame that ended in the terminator
  task automatic decode_frame();
    int sel;
    sel = 3;
    if (body[FUNC_POS] == dim_code) begin
      // lowest output wins when device codes coincide
      if (body[DEV_POS] == dev_code[0]) sel = 0;
      else if (body[DEV_POS] == dev_code[1]) sel = 1;
      else if (body[DEV_POS] == dev_code[2]) sel = 2;
      if (sel < 3) devices[sel] = (body[LEVEL_POS] > threshold);
      push_status_frames();
    end else if (body[FUNC_POS] == status_code) begin
      push_status_frames();
    end
  endtask

  // expected response words for one command word
  task automatic compute_responses(input cmd_word_t w);
    frame_event_t ev;
    ev = receiving ? EV_RECEIVING : EV_NONE;
    case (w.action)
      ACT_BYTE: begin
        if (!receiving) begin
          if (w.rx_byte == START_BYTE) begin
            receiving  = 1'b1;
            body_count = 0;
            tick_count = '0;
            ev = EV_RECEIVING;
          end else begin
            ev = EV_NONE;
          end
        end else begin
          body[body_count] = w.rx_byte;
          body_count++;
          if (body_count >= BODY_LEN) begin
            if (body[BODY_LAST] == END_BYTE) begin
              decode_frame();
              ev = EV_ACCEPTED;
            end else begin
              ev = EV_BAD_END;
            end
            drop_frame();
          end else begin
            ev = EV_RECEIVING;
          end
        end
      end
      ACT_BUTTON: begin
        // buttons are ignored while a frame is coming in
        if (!receiving) begin
          if (w.button_mask[0]) devices[0] = ~devices[0];
          else if (w.button_mask[1]) devices[1] = ~devices[1];
          else if (w.button_mask[2]) devices[2] = ~devices[2];
          ev = EV_NONE;
        end
      end
      ACT_TICK: begin
        if (receiving) begin
          if (tick_count >= timeout_lim) begin
            drop_frame();
            ev = EV_TIMEOUT;
          end else begin
            tick_count++;
            ev = EV_RECEIVING;
          end
        end else begin
          ev = EV_NONE;
        end
      end
      default: ;
    endcase
    push_word(1'b0, 8'h00, 1'b1, ev);
  endtask

  task automatic check_response(input rsp_word_t got);
    rsp_word_t want;
    if (due_responses.size() == 0) begin
      flag_failure($sformatf("unexpected word has=%0d tx=%h last=%0d dev=%b ev=%0d",
                             got.has_byte, got.tx_byte, got.last_of_run,
                             got.device_outputs, got.frame_event));
    end else begin
      want = due_responses.pop_front();
      if (got.has_byte !== want.has_byte || got.tx_byte !== want.tx_byte ||
          got.last_of_run !== want.last_of_run ||
          got.device_outputs !== want.device_outputs ||
          got.frame_event !== want.frame_event) begin
        flag_failure($sformatf({"mismatch: expected has=%0d tx=%h last=%0d dev=%b ev=%0d,",
                                " got has=%0d tx=%h last=%0d dev=%b ev=%0d"},
                               want.has_byte, want.tx_byte, want.last_of_run,
                               want.device_outputs, want.frame_event,
                               got.has_byte, got.tx_byte, got.last_of_run,
                               got.device_outputs, got.frame_event));
      end
    end
  endtask

  // watch all three ports at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      dim_code    = RST_DIM_CODE;
      status_code = RST_STATUS_CODE;
      dev_code[0] = RST_DEV1_CODE;
      dev_code[1] = RST_DEV2_CODE;
      dev_code[2] = RST_DEV3_CODE;
      threshold   = RST_THRESHOLD;
      timeout_lim = RST_TIMEOUT;
      devices     = 3'b000;
      fail_count  = 0;
      drop_frame();
      due_responses.delete();
    end else begin
      if (rsp_valid && !rsp_stall) check_response(rsp);
      if (cfg_we) begin
        case (cfg_index)
          REG_DIM_CODE:    dim_code    = cfg_data[7:0];
          REG_STATUS_CODE: status_code = cfg_data[7:0];
          REG_DEV1_CODE:   dev_code[0] = cfg_data[7:0];
          REG_DEV2_CODE:   dev_code[1] = cfg_data[7:0];
          REG_DEV3_CODE:   dev_code[2] = cfg_data[7:0];
          REG_THRESHOLD:   threshold   = cfg_data[7:0];
          REG_TIMEOUT:     timeout_lim = cfg_data;
          default: ;
        endcase
      end
      if (cmd_valid && !cmd_stall) compute_responses(cmd);
    end
    pending    = due_responses.size();
    frame_open = receiving;
  end

endmodule

FILE: bench/tb_top.sv
// Top of the serial command frame controller bench: clock, reset, command and
// config stimulus, random response stalls and the final verdict.
// Depends on scfc_pkg, serial_command_frame_controller and scfc_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import scfc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam logic [1:0] ACT_NOP = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  cmd_valid;
  logic                  cmd_stall;
  cmd_word_t             cmd;
  logic                  rsp_valid;
  logic                  rsp_stall;
  rsp_word_t             rsp;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int   fail_count;
  int   pending;
  logic frame_open;
  bit   calm;
  int   sent;
  int   cycles = 0;

  // register values as last written, used to aim frames at real codes
  logic [7:0]  cur_dim;
  logic [7:0]  cur_status;
  logic [7:0]  cur_dev [3];
  logic [7:0]  cur_thr;
  logic [23:0] cur_timeout;

  serial_command_frame_controller DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  scfc_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .frame_open (frame_open)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // response stalls in random bursts, none once calm
  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      rsp_stall <= 1'b0;
    end
  end

  // one command word, with an optional gap before it
  task automatic send(input logic [1:0] act, input logic [7:0] b, input logic [2:0] m);
    cmd_word_t w;
    w.action      = act;
    w.rx_byte     = b;
    w.button_mask = m;
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= w;
    do @(posedge clk); while (cmd_stall);
    sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send(ACT_BYTE, b, 3'($urandom_range(0, 7)));
  endtask

  task automatic send_other(input logic [1:0] act);
    send(act, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
  endtask

  // wait until every expected word has come out
  task automatic drain();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // close any half-received frame so config can change while idle
  task automatic flush();
    drain();
    if (frame_open) begin
      repeat (BODY_LEN) send_byte(8'h00);
      drain();
    end
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_DIM_CODE:    cur_dim     = v[7:0];
      REG_STATUS_CODE: cur_status  = v[7:0];
      REG_DEV1_CODE:   cur_dev[0]  = v[7:0];
      REG_DEV2_CODE:   cur_dev[1]  = v[7:0];
      REG_DEV3_CODE:   cur_dev[2]  = v[7:0];
      REG_THRESHOLD:   cur_thr     = v[7:0];
      REG_TIMEOUT:     cur_timeout = v;
      default: ;
    endcase
  endtask

  // all registers; unused upper data bits of the byte registers get noise
  task automatic program_all(input logic [7:0] dim, input logic [7:0] status,
                             input logic [7:0] d1, input logic [7:0] d2,
                             input logic [7:0] d3, input logic [7:0] thr,
                             input logic [23:0] tmo);
    logic [15:0] junk;
    junk = 16'($urandom_range(0, 65535));
    set_reg(REG_DIM_CODE, {junk, dim});
    set_reg(REG_STATUS_CODE, {~junk, status});
    set_reg(REG_DEV1_CODE, {junk, d1});
    set_reg(REG_DEV2_CODE, {~junk, d2});
    set_reg(REG_DEV3_CODE, {junk, d3});
    set_reg(REG_THRESHOLD, {~junk, thr});
    set_reg(REG_TIMEOUT, tmo);
  endtask

  function automatic logic [7:0] pick_func();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return cur_dim;
    if (r < 7) return cur_status;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_dev();
    int unsigned r;
    r = $urandom_range(0, 4);
    if (r < 3) return cur_dev[2'(r)];
    return 8'($urandom_range(0, 255));
  endfunction

  // levels cluster around the threshold
  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 5))
      0: return cur_thr;
      1: return cur_thr + 8'd1;
      2: return cur_thr - 8'd1;
      3: return 8'h00;
      4: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // start byte plus eleven body bytes, with stray words mixed in
  task automatic send_frame(input logic [7:0] func, input logic [7:0] dev,
                            input logic [7:0] level, input logic [7:0] last);
    logic [7:0] b;
    send_byte(START_BYTE);
    for (int i = 0; i < BODY_LEN; i++) begin
      case (i)
        FUNC_POS:  b = func;
        DEV_POS:   b = dev;
        LEVEL_POS: b = level;
        BODY_LAST: b = last;
        default:   b = ($urandom_range(0, 7) == 0) ? START_BYTE : 8'($urandom_range(0, 255));
      endcase
      send_byte(b);
      if (i < BODY_LAST) begin
        case ($urandom_range(0, 15))
          0, 1: send_other(ACT_TICK);
          2:    send_other(ACT_BUTTON);
          3:    send_other(ACT_NOP);
          default: ;
        endcase
      end
    end
  endtask

  // well-formed frames half the time, the rest noise and broken frames
  task automatic random_part(input int n);
    int goal;
    int unsigned r;
    logic [7:0] last;
    goal = sent + n;
    while (sent < goal) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        send_frame(pick_func(), pick_dev(), pick_level(), END_BYTE);
      end else if (r < 60) begin
        last = 8'($urandom_range(0, 255));
        if (last == END_BYTE) last = 8'h00;
        send_frame(pick_func(), pick_dev(), pick_level(), last);
      end else if (r < 68) begin
        // frame cut short, then left to time out where the limit is small
        send_byte(START_BYTE);
        repeat ($urandom_range(0, 9)) send_byte(8'($urandom_range(0, 255)));
        if (cur_timeout <= 40) repeat (cur_timeout + 1) send_other(ACT_TICK);
      end else if (r < 80) begin
        send_other(ACT_BUTTON);
      end else if (r < 90) begin
        repeat ($urandom_range(1, 3)) send_other(ACT_TICK);
      end else if (r < 96) begin
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_other(ACT_NOP);
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd       = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    calm      = 1'b0;
    sent      = 0;
    cur_dim     = RST_DIM_CODE;
    cur_status  = RST_STATUS_CODE;
    cur_dev[0]  = RST_DEV1_CODE;
    cur_dev[1]  = RST_DEV2_CODE;
    cur_dev[2]  = RST_DEV3_CODE;
    cur_thr     = RST_THRESHOLD;
    cur_timeout = RST_TIMEOUT;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // idle extremes: dropped bytes, tick, unused action, buttons
    send(ACT_BYTE, 8'h00, 3'b000);
    send(ACT_BYTE, 8'hFF, 3'b111);
    send(ACT_TICK, 8'h00, 3'b000);
    send(ACT_NOP, 8'hFF, 3'b111);
    send(ACT_BUTTON, 8'h00, 3'b000);
    send(ACT_BUTTON, 8'hFF, 3'b111);
    send(ACT_BUTTON, 8'h00, 3'b110);
    send(ACT_BUTTON, 8'h00, 3'b100);

    // dim frame with a start byte as data and stray words inside
    send_byte(START_BYTE);
    send_byte(cur_dim);
    send_byte(cur_dev[1]);
    send_byte(START_BYTE);
    send(ACT_TICK, 8'hFF, 3'b111);
    send(ACT_BUTTON, 8'hFF, 3'b111);
    send(ACT_NOP, 8'h00, 3'b000);
    repeat (6) send_byte(8'($urandom_range(0, 255)));
    send_byte(cur_thr + 8'd1);
    send_byte(END_BYTE);

    random_part(30);
    flush();

    // low extremes, shared device codes, one-tick timeout
    program_all(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 24'd1);
    random_part(30);
    flush();

    // equal function codes, top threshold, longest timeout
    program_all(8'hFF, 8'hFF, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'hFF, 24'hFFFFFF);
    random_part(30);
    flush();

    // random settings with a short timeout; the tail runs without stalls
    program_all(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                24'($urandom_range(2, 12)));
    random_part(15);
    calm = 1'b1;
    random_part(15);
    drain();
    repeat (10) @(posedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: serial_command_frame_controller.f
sv/scfc_pkg.sv
sv/scfc_out_queue.sv
sv/serial_command_frame_controller.sv
bench/scfc_checker.sv
bench/tb_top.sv
